[rtl/core/prlg_pkg.sv]
// Package for the PIN retry lockout guard: operation and register codes,
// field widths and result types. No dependencies.
package prlg_pkg;

    localparam int MAX_CODE_CHARS   = 8;
    localparam int MIN_CODE_CHARS   = 4;
    localparam int LOCKOUT_SECONDS  = 300;
    localparam int TICKS_PER_SECOND = 1000;

    localparam int CODE_W   = 64;
    localparam int LEN_W    = 4;
    localparam int COUNT_W  = 4;
    localparam int TICKS_W  = 22;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RESET =
        TICKS_W'(LOCKOUT_SECONDS * TICKS_PER_SECOND);
    localparam logic [COUNT_W-1:0] MAX_FAILURES_RESET = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
    localparam logic [LEN_W-1:0]   MIN_LEN = LEN_W'(MIN_CODE_CHARS);
    localparam logic [LEN_W-1:0]   MAX_LEN = LEN_W'(MAX_CODE_CHARS);

    typedef enum logic [OP_W-1:0] {
        OP_VERIFY = 2'd0,
        OP_RESET  = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STORED_CODE   = 2'd0,
        REG_STORED_LENGTH = 2'd1,
        REG_MAX_FAILURES  = 2'd2,
        REG_LOCKOUT_TICKS = 2'd3
    } cfg_index_t;

    // Outcome of the code compare, handed to the retry counter logic.
    typedef struct packed {
        logic check_off;   // stored length below the minimum
        logic code_match;  // lengths equal and all compared bytes equal
    } cmp_result_t;

endpackage

[rtl/core/pin_retry_lockout_guard_unit.sv]
// PIN retry limit with lockout timer: top level with stream ports and config port.
// Depends on prlg_pkg and prlg_code_compare.
//
// Each input transaction goes through the input register and the result register.
// Throughput: one item per cycle while m_tready holds; the failure count and lockout
// countdown are updated as each item moves from the input to the result register.
// Reset: aresetn is synchronous, active low; it empties both stages, clears the
// failure count and lockout, and loads register defaults (3 tries, 300000 ticks).
module pin_retry_lockout_guard_unit import prlg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [63:0] entered_code, [67:64] entered_length, [71:68] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]       s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] granted, [4:1] tries_left, [5] locked_out, [7:6] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CODE_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [CODE_W-1:0]  stored_code_reg;
    logic [LEN_W-1:0]   stored_length_reg;
    logic [COUNT_W-1:0] max_failures_reg;
    logic [TICKS_W-1:0] lockout_ticks_reg;

    // Guard state.
    logic [COUNT_W-1:0] fail_cnt_reg, fail_cnt_next;
    logic [TICKS_W-1:0] lock_reg, lock_next;

    // Input stage.
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [CODE_W-1:0]  in_code_reg;
    logic [LEN_W-1:0]   in_len_reg;

    // Result stage.
    logic               out_valid_reg;
    logic               granted_reg, granted_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic               locked_reg;

    logic               advance;
    cmp_result_t        cmp;
    logic [COUNT_W-1:0] fail_inc;
    logic [TICKS_W-1:0] lock_dec;
    logic [TICKS_W-1:0] lock_load;

    // The config port is always open; the user must write only while the block is idle, which it does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_code_reg   <= '0;
            stored_length_reg <= '0;
            max_failures_reg  <= MAX_FAILURES_RESET;
            lockout_ticks_reg <= LOCKOUT_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STORED_CODE:   stored_code_reg   <= cfg_data;
                REG_STORED_LENGTH: stored_length_reg <= cfg_data[LEN_W-1:0];
                REG_MAX_FAILURES:  max_failures_reg  <= cfg_data[COUNT_W-1:0];
                REG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // The item in the input register moves on whenever the result register
    // is empty or its transaction completes this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= op_t'(s_tuser);
            in_code_reg <= s_tdata[CODE_W-1:0];
            in_len_reg  <= s_tdata[CODE_W +: LEN_W];
        end
    end

    prlg_code_compare u_compare (
        .stored_code    (stored_code_reg),
        .stored_length  (stored_length_reg),
        .entered_code   (in_code_reg),
        .entered_length (in_len_reg),
        .result         (cmp)
    );

    assign fail_inc  = (fail_cnt_reg == COUNT_SAT) ? COUNT_SAT : fail_cnt_reg + 1'b1;
    assign lock_dec  = lock_reg - 1'b1;
    // A zero lockout length still locks for one tick.
    assign lock_load = (lockout_ticks_reg != '0) ? lockout_ticks_reg : TICKS_W'(1);

    // Per-item update of the failure count and lockout countdown.
    always_comb begin
        fail_cnt_next = fail_cnt_reg;
        lock_next     = lock_reg;
        granted_next  = 1'b0;
        left_next     = '0;
        case (in_op_reg)
            OP_VERIFY: begin
                if (lock_reg != '0) begin
                    left_next = '0;
                end else if (cmp.check_off) begin
                    granted_next = 1'b1;
                    left_next    = max_failures_reg;
                end else if (cmp.code_match) begin
                    granted_next  = 1'b1;
                    fail_cnt_next = '0;
                    left_next     = max_failures_reg;
                end else begin
                    fail_cnt_next = fail_inc;
                    left_next = (max_failures_reg > fail_inc) ?
                                max_failures_reg - fail_inc : '0;
                    if (fail_inc >= max_failures_reg) begin
                        lock_next = lock_load;
                    end
                end
            end
            default: begin
                if (in_op_reg == OP_RESET) begin
                    fail_cnt_next = '0;
                    lock_next     = '0;
                end else if (in_op_reg == OP_TICK && lock_reg != '0) begin
                    lock_next = lock_dec;
                    // Countdown expiry forgives the earlier failures.
                    if (lock_dec == '0) begin
                        fail_cnt_next = '0;
                    end
                end
                if (lock_next != '0) begin
                    left_next = '0;
                end else begin
                    left_next = (max_failures_reg > fail_cnt_next) ?
                                max_failures_reg - fail_cnt_next : '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_cnt_reg <= '0;
            lock_reg     <= '0;
        end else if (advance) begin
            fail_cnt_reg <= fail_cnt_next;
            lock_reg     <= lock_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            granted_reg <= granted_next;
            left_reg    <= left_next;
            locked_reg  <= (lock_next != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, locked_reg, left_reg, granted_reg};

    // A locked-out result never shows tries left or a grant.
    a_locked_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && locked_reg) |-> (left_reg == '0 && !granted_reg))
        else $error("locked result with tries left or grant");

    // A reset item clears both the count and the lockout.
    a_reset_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_RESET) |=> (fail_cnt_reg == '0 && lock_reg == '0))
        else $error("reset item did not clear state");

    // The last tick of a lockout clears the failure count.
    a_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_TICK && lock_reg == TICKS_W'(1))
        |=> (fail_cnt_reg == '0 && lock_reg == '0))
        else $error("lockout expiry did not clear failures");

    // A verify during lockout leaves the guard state untouched.
    a_locked_verify: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_VERIFY && lock_reg != '0)
        |=> ($stable(fail_cnt_reg) && $stable(lock_reg)))
        else $error("verify changed state while locked");

endmodule

[rtl/core/prlg_code_compare.sv]
// Masked byte compare of an entered PIN against the stored PIN.
// Depends on prlg_pkg.
module prlg_code_compare import prlg_pkg::*; (
    input  logic [CODE_W-1:0] stored_code,
    input  logic [LEN_W-1:0]  stored_length,
    input  logic [CODE_W-1:0] entered_code,
    input  logic [LEN_W-1:0]  entered_length,
    output cmp_result_t       result
);

    logic [LEN_W-1:0]          n_chars;
    logic [MAX_CODE_CHARS-1:0] byte_diff;
    logic [CODE_W-1:0]         diff;

    assign n_chars = (entered_length > MAX_LEN) ? MAX_LEN : entered_length;
    assign diff    = entered_code ^ stored_code;

    // Only the first n_chars bytes take part in the compare.
    always_comb begin
        for (int i = 0; i < MAX_CODE_CHARS; i++) begin
            byte_diff[i] = (LEN_W'(i) < n_chars) && (diff[8*i +: 8] != 8'h00);
        end
    end

    assign result.check_off  = (stored_length < MIN_LEN);
    assign result.code_match = (entered_length == stored_length) && (byte_diff == '0);

endmodule
